>>> sv/bcd_pkg.sv
// ----------------------------------------------------------------------------
// bcd_pkg
// Shared types and constants for the button click / hold detector.
// ----------------------------------------------------------------------------
package bcd_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned TallyW = 8;
  localparam int unsigned KindW  = 3;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [TallyW-1:0] TallyMax = 8'd255;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgClickGap   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHoldTime   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgStuckTime  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgTickPeriod = 2'd3;

  typedef enum logic [KindW-1:0] {
    EV_NONE       = 3'd0,
    EV_CLICK      = 3'd1,
    EV_HOLD_START = 3'd2,
    EV_HOLD_TICK  = 3'd3,
    EV_HOLD_END   = 3'd4
  } ev_kind_e;

  typedef struct packed {
    logic             level_pressed;
    logic [TimeW-1:0] time_now;
  } in_req_t;

  typedef struct packed {
    logic [KindW-1:0]  event_kind;
    logic [TallyW-1:0] click_total;
  } out_req_t;

  typedef struct packed {
    logic [TimeW-1:0] click_gap_time;
    logic [TimeW-1:0] hold_time;
    logic [TimeW-1:0] stuck_time;
    logic [TimeW-1:0] tick_period;
  } cfg_t;

endpackage

>>> sv/button_click_hold_detector.sv
// ----------------------------------------------------------------------------
// button_click_hold_detector
// Turns timestamped button samples into click, hold start, hold tick and
// hold end events; one event per sample.
// ----------------------------------------------------------------------------
//
//   channel   signals                          direction  moves
//   in        in_valid_i/in_ready_o/in_req_i   to block   level + timestamp
//   out       out_valid_o/out_ready_i/out_req_o from block event + click count
//   cfg       cfg_we_i/cfg_idx_i/cfg_data_i    to block   timing registers
//
// One request per cycle sustained while the output is not stalled. A request
// sits in the input register, the event logic runs in one pass and lands in
// the output register.
// Reset restores the timing registers to their defaults and clears the valid flags and the detector state.
// A stalled output holds the result; the input register then holds too and
// in_ready_o drops once it is full.
//
module button_click_hold_detector
  import bcd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_req_t            in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_req_t           out_req_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [TimeW-1:0]   cfg_data_i
);

  cfg_t     cfg;
  logic     in_valid_q;
  in_req_t  in_q;
  logic     out_valid_q;
  out_req_t out_q;
  out_req_t result;
  logic     out_free;
  logic     advance;

  bcd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Advance the input register into the output register when it can take it
  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  // Capture the sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_req_i;
    end
  end

  // State updates only when the event is committed to the output register
  bcd_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .sample_i (in_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  // A click event always carries a nonzero count
  a_click_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.event_kind == EV_CLICK |-> out_req_o.click_total != '0)
    else $error("click event with zero count");

  // Only click events carry a count
  a_count_only_click: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.event_kind != EV_CLICK |-> out_req_o.click_total == '0)
    else $error("count on a non-click event");

  // A full input register behind a stalled output stays full and unchanged
  a_input_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !out_ready_i |=> in_valid_q && $stable(in_q))
    else $error("input register lost a sample during stall");

endmodule

>>> sv/bcd_cfg.sv
// ----------------------------------------------------------------------------
// bcd_cfg
// Configuration register file: four 32-bit timing registers.
// ----------------------------------------------------------------------------
module bcd_cfg
  import bcd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [TimeW-1:0]   cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.click_gap_time <= 32'd400;
      cfg_q.hold_time      <= 32'd500;
      cfg_q.stuck_time     <= 32'd60000;
      cfg_q.tick_period    <= 32'd30;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgClickGap:   cfg_q.click_gap_time <= cfg_data_i;
        CfgHoldTime:   cfg_q.hold_time      <= cfg_data_i;
        CfgStuckTime:  cfg_q.stuck_time     <= cfg_data_i;
        CfgTickPeriod: cfg_q.tick_period    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/bcd_step.sv
// ----------------------------------------------------------------------------
// bcd_step
// Detector state and the per-sample event logic.
// ----------------------------------------------------------------------------
module bcd_step
  import bcd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  in_req_t  sample_i,
  input  cfg_t     cfg_i,
  output out_req_t result_o
);

  logic              was_pressed_q, was_pressed_d;
  logic [TimeW-1:0]  press_begin_q, press_begin_d;
  logic              is_holding_q, is_holding_d;
  logic              is_stuck_q, is_stuck_d;
  logic [TallyW-1:0] click_tally_q, click_tally_d;
  logic [TimeW-1:0]  release_time_q, release_time_d;
  logic [TimeW-1:0]  tick_time_q, tick_time_d;

  logic [TimeW-1:0]  since_press, since_release, since_tick;
  logic              gap_passed;
  ev_kind_e          kind;
  logic [TallyW-1:0] total;

  // Elapsed times wrap modulo 2^32
  assign since_press   = sample_i.time_now - press_begin_q;
  assign since_release = sample_i.time_now - release_time_q;
  assign since_tick    = sample_i.time_now - tick_time_q;
  assign gap_passed    = since_release > cfg_i.click_gap_time;

  always_comb begin
    was_pressed_d  = was_pressed_q;
    press_begin_d  = press_begin_q;
    is_holding_d   = is_holding_q;
    is_stuck_d     = is_stuck_q;
    click_tally_d  = click_tally_q;
    release_time_d = release_time_q;
    tick_time_d    = tick_time_q;
    kind           = EV_NONE;
    total          = '0;

    if (sample_i.level_pressed && !was_pressed_q) begin
      // press edge: keep any pending click run
      was_pressed_d = 1'b1;
      press_begin_d = sample_i.time_now;
      is_holding_d  = 1'b0;
      is_stuck_d    = 1'b0;
    end else if (!sample_i.level_pressed && was_pressed_q) begin
      was_pressed_d = 1'b0;
      if (is_holding_q) begin
        is_holding_d  = 1'b0;
        click_tally_d = '0;
        kind          = EV_HOLD_END;
      end else begin
        if (click_tally_q == '0 || gap_passed) begin
          click_tally_d = TallyW'(1);
        end else if (click_tally_q != TallyMax) begin
          click_tally_d = click_tally_q + TallyW'(1);
        end
        release_time_d = sample_i.time_now;
      end
    end else if (sample_i.level_pressed) begin
      if (!is_holding_q) begin
        if (since_press > cfg_i.hold_time) begin
          is_holding_d  = 1'b1;
          click_tally_d = '0;
          tick_time_d   = sample_i.time_now;
          kind          = EV_HOLD_START;
        end
      end else if (!is_stuck_q && since_press > cfg_i.stuck_time) begin
        is_stuck_d = 1'b1;
      end else if (!is_stuck_q && since_tick > cfg_i.tick_period) begin
        tick_time_d = sample_i.time_now;
        kind        = EV_HOLD_TICK;
      end
    end else begin
      if (click_tally_q != '0 && gap_passed) begin
        kind          = EV_CLICK;
        total         = click_tally_q;
        click_tally_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_pressed_q  <= 1'b0;
      press_begin_q  <= '0;
      is_holding_q   <= 1'b0;
      is_stuck_q     <= 1'b0;
      click_tally_q  <= '0;
      release_time_q <= '0;
      tick_time_q    <= '0;
    end else if (step_i) begin
      was_pressed_q  <= was_pressed_d;
      press_begin_q  <= press_begin_d;
      is_holding_q   <= is_holding_d;
      is_stuck_q     <= is_stuck_d;
      click_tally_q  <= click_tally_d;
      release_time_q <= release_time_d;
      tick_time_q    <= tick_time_d;
    end
  end

  assign result_o.event_kind  = kind;
  assign result_o.click_total = total;

endmodule

>>> tb/sv/tb_button_click_hold_detector.sv
// ----------------------------------------------------------------------------
// tb_button_click_hold_detector
// Self-checking bench: drives timestamped button samples through the
// valid/ready input, rebuilds the expected event of every sample in a
// cycle-free model kept here, and checks each output request against it.
// ----------------------------------------------------------------------------
module tb_button_click_hold_detector
  import bcd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ClkPeriod  = 4;
  localparam int unsigned ResetCycles = 7;
  localparam int unsigned IdleMax    = 8;
  localparam int unsigned LongHold   = 60;      // receiver back-pressure stretch
  localparam int unsigned CycleLimit = 400_000;
  localparam int unsigned SettleCycles = 8;     // margin after the last expected result

  localparam cfg_t ResetTiming = '{32'd400, 32'd500, 32'd60000, 32'd30};

  // One row of the directed sequence. Where the event can be read off the
  // timing defaults at a glance it is typed in; other rows use the model.
  typedef struct packed {
    logic              lvl;
    logic [TimeW-1:0]  stamp;
    logic              typed;
    ev_kind_e          kind;
    logic [TallyW-1:0] total;
  } probe_row_t;

  // Runs against the reset timing: gap 400, hold 500, stuck 60000, tick 30.
  localparam probe_row_t ProbeRows [25] = '{
    '{1'b0, 32'd0,          1'b1, EV_NONE,       8'd0},  // idle right after reset
    '{1'b1, 32'd10,         1'b1, EV_NONE,       8'd0},  // press edge is silent
    '{1'b0, 32'd50,         1'b1, EV_NONE,       8'd0},  // first release opens a run
    '{1'b1, 32'd100,        1'b0, EV_NONE,       8'd0},
    '{1'b0, 32'd150,        1'b0, EV_NONE,       8'd0},  // second click joins the run
    '{1'b0, 32'd550,        1'b1, EV_NONE,       8'd0},  // gap exactly met, not passed
    '{1'b0, 32'd551,        1'b1, EV_CLICK,      8'd2},  // gap passed: report run
    '{1'b1, 32'd1000,       1'b0, EV_NONE,       8'd0},
    '{1'b1, 32'd1500,       1'b1, EV_NONE,       8'd0},  // hold time exactly met
    '{1'b1, 32'd1501,       1'b1, EV_HOLD_START, 8'd0},
    '{1'b1, 32'd1531,       1'b0, EV_NONE,       8'd0},  // tick period exactly met
    '{1'b1, 32'd1532,       1'b1, EV_HOLD_TICK,  8'd0},
    '{1'b0, 32'd1600,       1'b1, EV_HOLD_END,   8'd0},
    '{1'b0, 32'd3000,       1'b1, EV_NONE,       8'd0},  // a hold is never a click
    '{1'b1, 32'd4000,       1'b0, EV_NONE,       8'd0},
    '{1'b1, 32'd4501,       1'b0, EV_NONE,       8'd0},
    '{1'b1, 32'd64000,      1'b0, EV_NONE,       8'd0},  // stuck time met: still ticks
    '{1'b1, 32'd64001,      1'b0, EV_NONE,       8'd0},  // stuck latches silently
    '{1'b1, 32'd64100,      1'b0, EV_NONE,       8'd0},  // no ticks while stuck
    '{1'b0, 32'd64200,      1'b1, EV_HOLD_END,   8'd0},
    '{1'b1, 32'hFFFF_FF00,  1'b0, EV_NONE,       8'd0},  // press across the wrap
    '{1'b0, 32'h0000_0010,  1'b0, EV_NONE,       8'd0},
    '{1'b1, 32'h0000_0020,  1'b0, EV_NONE,       8'd0},  // press keeps pending run
    '{1'b0, 32'h0000_0030,  1'b0, EV_NONE,       8'd0},
    '{1'b0, 32'hFFFF_FFFF,  1'b0, EV_NONE,       8'd0}   // top timestamp ends run
  };

  typedef struct packed {
    logic              pressed;
    logic [TimeW-1:0]  press_t;
    logic              holding;
    logic              stuck;
    logic [TallyW-1:0] tally;
    logic [TimeW-1:0]  release_t;
    logic [TimeW-1:0]  tick_t;
  } btn_state_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  in_req_t            in_req_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_req_t           out_req_o;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = CfgClickGap;
  logic [TimeW-1:0]   cfg_data_i = '0;

  // Model of the detector: timing registers and button state
  cfg_t             timing = ResetTiming;
  btn_state_t       btn = '0;
  out_req_t         event_q [$];

  logic [TimeW-1:0] clock_ms = '0;    // running timestamp of the stimulus
  int unsigned      sent = 0;
  int unsigned      mismatch_count = 0;
  int unsigned      cycles = 0;
  int unsigned      tx_idle_max = IdleMax;
  int unsigned      rx_idle_max = IdleMax;
  int unsigned      rx_wait = 0;
  bit               long_hold_req = 1'b0;

  button_click_hold_detector u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Elapsed ms between two timestamps, modulo 2^32
  function automatic logic [TimeW-1:0] elapsed(input logic [TimeW-1:0] now,
                                                input logic [TimeW-1:0] mark);
    return now - mark;
  endfunction

  // Advance the button state by one sample and return the event it causes.
  function automatic out_req_t advance_detector(input in_req_t r);
    out_req_t         res;
    logic [TimeW-1:0] t;
    res.event_kind  = EV_NONE;
    res.click_total = '0;
    t = r.time_now;
    if (r.level_pressed && !btn.pressed) begin
      // press edge: restart hold tracking, keep any pending click run
      btn.pressed = 1'b1;
      btn.press_t = t;
      btn.holding = 1'b0;
      btn.stuck   = 1'b0;
    end else if (!r.level_pressed && btn.pressed) begin
      btn.pressed = 1'b0;
      if (btn.holding) begin
        btn.holding    = 1'b0;
        btn.tally      = '0;
        res.event_kind = EV_HOLD_END;
      end else begin
        if (btn.tally == '0 || elapsed(t, btn.release_t) > timing.click_gap_time) begin
          btn.tally = TallyW'(1);
        end else if (btn.tally != TallyMax) begin
          btn.tally = btn.tally + 1'b1;
        end
        btn.release_t = t;
      end
    end else if (r.level_pressed) begin
      if (!btn.holding) begin
        if (elapsed(t, btn.press_t) > timing.hold_time) begin
          btn.holding    = 1'b1;
          btn.tally      = '0;
          btn.tick_t     = t;
          res.event_kind = EV_HOLD_START;
        end
      end else if (!btn.stuck && elapsed(t, btn.press_t) > timing.stuck_time) begin
        // stuck wins over a due tick and stays silent
        btn.stuck = 1'b1;
      end else if (!btn.stuck && elapsed(t, btn.tick_t) > timing.tick_period) begin
        btn.tick_t     = t;
        res.event_kind = EV_HOLD_TICK;
      end
    end else if (btn.tally != '0 && elapsed(t, btn.release_t) > timing.click_gap_time) begin
      res.event_kind  = EV_CLICK;
      res.click_total = btn.tally;
      btn.tally       = '0;
    end
    return res;
  endfunction

  // Step that lands on, just past, or well around a threshold
  function automatic logic [TimeW-1:0] span_near(input logic [TimeW-1:0] th);
    case ($urandom_range(0, 3))
      0:       return th;
      1:       return th + 1'b1;
      2:       return $urandom_range(0, th);
      default: return th + $urandom_range(1, 40);
    endcase
  endfunction

  // Step kept well below a threshold
  function automatic logic [TimeW-1:0] span_under(input logic [TimeW-1:0] th);
    return $urandom_range(0, th >> 2);
  endfunction

  // Offer one request, hold it until accepted, then log its expected event.
  // Valid is left high on return; the next call or a drain decides it.
  task automatic send_req(input logic lvl, input logic [TimeW-1:0] stamp,
                          input bit typed = 1'b0, input out_req_t typed_ev = '0);
    int unsigned pause;
    out_req_t    ev;
    pause = $urandom_range(0, tx_idle_max);
    if (pause > 0) begin
      in_valid_i <= 1'b0;
      repeat (pause) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= '{level_pressed: lvl, time_now: stamp};
    do @(posedge clk_i); while (!in_ready_o);
    ev = advance_detector(in_req_i);
    event_q.push_back(typed ? typed_ev : ev);
    sent++;
  endtask

  // Drop valid and wait until every expected event has come back
  task automatic drain_events();
    in_valid_i <= 1'b0;
    while (event_q.size() != 0) @(posedge clk_i);
  endtask

  // Write all four timing registers; call only with the block idle
  task automatic program_timing(input cfg_t c);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgClickGap;
    cfg_data_i <= c.click_gap_time;
    @(posedge clk_i);
    cfg_idx_i  <= CfgHoldTime;
    cfg_data_i <= c.hold_time;
    @(posedge clk_i);
    cfg_idx_i  <= CfgStuckTime;
    cfg_data_i <= c.stuck_time;
    @(posedge clk_i);
    cfg_idx_i  <= CfgTickPeriod;
    cfg_data_i <= c.tick_period;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    timing = c;
  endtask

  // A run of short clicks, then released samples that close it out
  task automatic click_burst(input int unsigned n);
    repeat (n) begin
      clock_ms += span_under(timing.click_gap_time);
      send_req(1'b1, clock_ms);
      if ($urandom_range(0, 3) == 0) begin
        clock_ms += span_under(timing.hold_time);
        send_req(1'b1, clock_ms);
      end
      clock_ms += span_under(timing.hold_time);
      send_req(1'b0, clock_ms);
    end
    clock_ms += span_near(timing.click_gap_time);
    send_req(1'b0, clock_ms);
    clock_ms += timing.click_gap_time + 1;
    send_req(1'b0, clock_ms);
  endtask

  // A long press: hold start, ticks, sometimes the stuck latch, release
  task automatic hold_run();
    logic [TimeW-1:0] began;
    clock_ms += span_near(timing.click_gap_time);
    send_req(1'b1, clock_ms);
    began = clock_ms;
    clock_ms += span_near(timing.hold_time);
    send_req(1'b1, clock_ms);
    repeat ($urandom_range(0, 6)) begin
      clock_ms += span_near(timing.tick_period);
      send_req(1'b1, clock_ms);
    end
    if ($urandom_range(0, 2) == 0) begin
      clock_ms = began + span_near(timing.stuck_time);
      send_req(1'b1, clock_ms);
      repeat ($urandom_range(1, 3)) begin
        clock_ms += span_near(timing.tick_period);
        send_req(1'b1, clock_ms);
      end
    end
    clock_ms += span_under(timing.tick_period);
    send_req(1'b0, clock_ms);
  endtask

  // Random levels at random timestamps
  task automatic noise_run(input int unsigned n);
    repeat (n) begin
      clock_ms = $urandom;
      send_req(1'($urandom_range(0, 1)), clock_ms);
    end
  endtask

  // One timing setting: program it, optionally open with a long burst,
  // then mix bursts, holds and noise until the request budget is spent.
  task automatic run_phase(input cfg_t c, input int unsigned budget,
                           input int unsigned opening_burst, input bit squeeze);
    int unsigned first;
    bit          squeezed;
    drain_events();
    program_timing(c);
    first    = sent;
    squeezed = 1'b0;
    clock_ms = $urandom;
    if (opening_burst > 0) click_burst(opening_burst);
    while (sent - first < budget) begin
      // stretches with no idling on either side
      tx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : IdleMax;
      rx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : IdleMax;
      if (squeeze && !squeezed && (sent - first) > budget / 2) begin
        // stall the receiver while requests keep coming, then pause the
        // sender until everything in flight has drained
        squeezed      = 1'b1;
        tx_idle_max   = 0;
        long_hold_req = 1'b1;
        hold_run();
        noise_run(12);
        drain_events();
      end else begin
        case ($urandom_range(0, 7))
          0, 1, 2, 3: click_burst($urandom_range(1, 6));
          4, 5, 6:    hold_run();
          default:    noise_run($urandom_range(2, 8));
        endcase
      end
    end
  endtask

  // Receiver: check each accepted result, then draw the next stall
  always @(posedge clk_i) begin
    out_req_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (event_q.size() == 0) begin
          $display("%0t: unexpected event: expected none, actual kind %0d total %0d",
                   $time, out_req_o.event_kind, out_req_o.click_total);
          mismatch_count++;
        end else begin
          want = event_q.pop_front();
          if (out_req_o.event_kind !== want.event_kind) begin
            $display("%0t: event_kind expected %0d actual %0d",
                     $time, want.event_kind, out_req_o.event_kind);
            mismatch_count++;
          end
          if (out_req_o.click_total !== want.click_total) begin
            $display("%0t: click_total expected %0d actual %0d",
                     $time, want.click_total, out_req_o.click_total);
            mismatch_count++;
          end
        end
        rx_wait = $urandom_range(0, rx_idle_max);
      end
      if (long_hold_req) begin
        rx_wait       = LongHold;
        long_hold_req = 1'b0;
      end
      if (rx_wait > 0) begin
        out_ready_i <= 1'b0;
        rx_wait--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    cfg_t mixed;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed sequence on the reset timing
    foreach (ProbeRows[i]) begin
      send_req(ProbeRows[i].lvl, ProbeRows[i].stamp, ProbeRows[i].typed,
               '{event_kind: ProbeRows[i].kind, click_total: ProbeRows[i].total});
    end

    // Short timings, with the back-pressure episode
    run_phase('{32'd20, 32'd40, 32'd300, 32'd5}, 300, 0, 1'b1);
    // All thresholds zero: any elapsed ms counts
    run_phase('{32'd0, 32'd0, 32'd0, 32'd0}, 200, 0, 1'b0);
    // All thresholds at the top: nothing ever expires
    run_phase('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 200, 0, 1'b0);
    // Wide gap so one burst climbs past the tally ceiling and reports it
    run_phase('{32'd100000, 32'd100000, 32'd1000000, 32'd1000}, 620, 270, 1'b0);
    // Two random small settings
    repeat (2) begin
      mixed.click_gap_time = $urandom_range(0, 60);
      mixed.hold_time      = $urandom_range(0, 80);
      mixed.stuck_time     = $urandom_range(0, 400);
      mixed.tick_period    = $urandom_range(0, 20);
      run_phase(mixed, 150, 0, 1'b0);
    end

    drain_events();
    // watch for stray results after the last expected one
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
